FILE: rtl/http_request_line_detector_macros.svh
// assertion macros shared by the rtl
`ifndef HTTP_REQUEST_LINE_DETECTOR_MACROS_SVH
`define HTTP_REQUEST_LINE_DETECTOR_MACROS_SVH

// same-cycle implication
`define HRLD_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("hrld assertion failed");

// next-cycle implication
`define HRLD_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("hrld assertion failed");

`endif

FILE: rtl/hrld_pkg.sv
package hrld_pkg;

    localparam int METHOD_COUNT = 9;
    localparam int METHOD_MAX   = 7;

    localparam int FRONT_DEPTH  = 4;
    localparam int FRONT_PTR_W  = $clog2(FRONT_DEPTH);
    localparam int FRONT_CNT_W  = $clog2(FRONT_DEPTH + 1);

    localparam int RES_DEPTH    = 2;
    localparam int RES_PTR_W    = $clog2(RES_DEPTH);
    localparam int RES_CNT_W    = $clog2(RES_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;

    // names left aligned, padded to the longest name
    localparam logic [8*METHOD_MAX-1:0] METHOD_NAMES [METHOD_COUNT] = '{
        "GET    ", "POST   ", "PUT    ", "DELETE ", "PATCH  ",
        "HEAD   ", "CONNECT", "TRACE  ", "OPTIONS"
    };
    localparam logic [2:0] METHOD_LENS [METHOD_COUNT] = '{
        3'd3, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd7, 3'd5, 3'd7
    };

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_METHOD,
        PH_SLASH_WS,
        PH_D_WS,
        PH_D_T1,
        PH_D_T2,
        PH_D_P,
        PH_D_SL,
        PH_MAJ_WS,
        PH_MAJ_SIGN,
        PH_MAJ_DIG,
        PH_MIN_WS,
        PH_MIN_SIGN,
        PH_MIN_DIG,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef enum logic [2:0] {
        PT_OFF,
        PT_WS,
        PT_TOKEN,
        PT_GAP,
        PT_T1,
        PT_T2,
        PT_P,
        PT_SL
    } path_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ws;
        logic       dig;
    } item_t;

    function automatic logic [7:0] method_char(input int idx, input logic [2:0] pos);
        int sel;
        sel = (METHOD_MAX - 1) - int'(pos);
        if (sel < 0)
        begin
            sel = 0;
        end
        return METHOD_NAMES[idx][8*sel +: 8];
    endfunction

endpackage

FILE: rtl/http_request_line_detector.sv
// http request line detector
// input channel: push with data_byte and last_byte, one byte of a message per
// transaction, refused while full is high. last_byte marks the final byte.
// result channel: one transaction per message, is_request valid while empty is
// low, taken with pop. is_request is 1 when the message opens with a request
// line (method, slash, optional path, HTTP/major.minor, major >= 1, minor >= 0).
// throughput: one byte per cycle while the result queue has room, set by the
// single-step byte parser. a byte waits in the 4-entry byte queue, and the parser
// writes the result queue at the edge that takes the byte from the queue head.
// a stalled receiver fills the 2-entry result queue; the parser then holds and
// the byte queue fills, raising full within four more bytes.
// reset: asynchronous, active low; clears both queues and the parser state,
// no clearing pass, the block takes bytes as soon as reset is released.
`include "http_request_line_detector_macros.svh"

module http_request_line_detector (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic       is_request
);
    import hrld_pkg::*;

    logic                 item_valid;
    item_t                item;
    logic                 item_ready;
    logic                 res_push;
    logic                 res_value;
    logic                 res_full;
    logic                 res_pop;

    logic                 res_q_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_reg, res_wr_next;
    logic [RES_PTR_W-1:0] res_rd_reg, res_rd_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    hrld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    hrld_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .res_push   (res_push),
        .res_value  (res_value),
        .res_full   (res_full)
    );

    // result queue
    assign empty      = (res_cnt_reg == '0);
    assign res_full   = (res_cnt_reg == RES_CNT_W'(RES_DEPTH));
    assign res_pop    = pop && !empty;
    assign is_request = res_q_reg[res_rd_reg];

    always_comb
    begin
        res_wr_next  = res_wr_reg;
        res_rd_next  = res_rd_reg;
        res_cnt_next = res_cnt_reg;
        if (res_push)
        begin
            res_wr_next = res_wr_reg + 1'b1;
        end
        if (res_pop)
        begin
            res_rd_next = res_rd_reg + 1'b1;
        end
        if (res_push && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + 1'b1;
        end
        else if (res_pop && !res_push)
        begin
            res_cnt_next = res_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            res_wr_reg  <= res_wr_next;
            res_rd_reg  <= res_rd_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_q_reg[res_wr_reg] <= res_value;
        end
    end

    `HRLD_ASSERT_IMP(a_top_no_overflow, clk, rst_n, res_push, !res_full)
    `HRLD_ASSERT_NXT(a_top_result_lands, clk, rst_n, res_push && !res_pop, !empty)

endmodule

FILE: rtl/hrld_front.sv
`include "http_request_line_detector_macros.svh"

module hrld_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [7:0]     data_byte,
    input  logic           last_byte,
    output logic           item_valid,
    output hrld_pkg::item_t item,
    input  logic           item_ready
);
    import hrld_pkg::*;

    item_t                  q_reg [FRONT_DEPTH];
    logic [FRONT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FRONT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FRONT_CNT_W-1:0] count_reg, count_next;
    item_t                  in_item;
    logic                   push_ok;
    logic                   pop_ok;

    // classify the incoming byte
    always_comb
    begin
        in_item.data = data_byte;
        in_item.last = last_byte;
        in_item.ws   = (data_byte == CH_SPACE) ||
                       ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
        in_item.dig  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    end

    assign full       = (count_reg == FRONT_CNT_W'(FRONT_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = q_reg[rd_ptr_reg];
    assign push_ok    = push && !full;
    assign pop_ok     = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    `HRLD_ASSERT_NXT(a_front_count_up, clk, rst_n, push_ok && !pop_ok, count_reg == $past(count_reg) + 1'b1)
    `HRLD_ASSERT_NXT(a_front_count_down, clk, rst_n, pop_ok && !push_ok, count_reg == $past(count_reg) - 1'b1)
    `HRLD_ASSERT_IMP(a_front_bound, clk, rst_n, 1'b1, count_reg <= FRONT_CNT_W'(FRONT_DEPTH))

endmodule

FILE: rtl/hrld_back.sv
`include "http_request_line_detector_macros.svh"

module hrld_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  hrld_pkg::item_t item,
    output logic            item_ready,
    output logic            res_push,
    output logic            res_value,
    input  logic            res_full
);
    import hrld_pkg::*;

    phase_t                  phase_reg, phase_next;
    path_t                   path_reg, path_next;
    logic [METHOD_COUNT-1:0] cand_reg, cand_next;
    logic [2:0]              pos_reg, pos_next;
    logic                    maj_neg_reg, maj_neg_next;
    logic                    maj_nz_reg, maj_nz_next;
    logic                    min_neg_reg, min_neg_next;
    logic                    min_nz_reg, min_nz_next;
    logic                    verdict_reg, verdict_next;
    logic                    ended_reg, ended_next;

    logic                    take;
    logic [7:0]              c;
    logic                    ws;
    logic                    dig;
    logic                    nonzero_dig;
    logic                    handover;
    logic                    do_method;
    logic                    method_ok;
    logic [METHOD_COUNT-1:0] cand_take;
    logic [2:0]              pos_take;
    logic                    clear_ver;
    phase_t                  np;
    path_t                   nb;

    assign item_ready  = !res_full;
    assign take        = item_valid && item_ready;
    assign c           = item.data;
    assign ws          = item.ws;
    assign dig         = item.dig;
    assign nonzero_dig = dig && (c != CH_ZERO);

    // method name matching, one byte a step
    always_comb
    begin
        method_ok = 1'b0;
        cand_take = cand_reg;
        pos_take  = pos_reg;
        for (int i = 0; i < METHOD_COUNT; i++)
        begin
            if (cand_reg[i] && (METHOD_LENS[i] == pos_reg))
            begin
                method_ok = 1'b1;
            end
            if ((METHOD_LENS[i] <= pos_reg) || (method_char(i, pos_reg) != c))
            begin
                cand_take[i] = 1'b0;
            end
        end
        if (pos_reg >= 3'(METHOD_MAX))
        begin
            cand_take = '0;
        end
        else
        begin
            pos_take = pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        path_next    = path_reg;
        cand_next    = cand_reg;
        pos_next     = pos_reg;
        maj_neg_next = maj_neg_reg;
        maj_nz_next  = maj_nz_reg;
        min_neg_next = min_neg_reg;
        min_nz_next  = min_nz_reg;
        verdict_next = verdict_reg;
        ended_next   = ended_reg;
        handover     = 1'b0;
        do_method    = 1'b0;
        clear_ver    = 1'b0;
        np           = phase_reg;
        nb           = path_reg;
        res_push     = 1'b0;
        res_value    = 1'b0;

        // path form tracker
        case (path_reg)
            PT_WS:    if (!ws) nb = PT_TOKEN;
            PT_TOKEN: if (ws) nb = PT_GAP;
            PT_GAP:   if (!ws) nb = (c == CH_H) ? PT_T1 : PT_OFF;
            PT_T1:    nb = (c == CH_T) ? PT_T2 : PT_OFF;
            PT_T2:    nb = (c == CH_T) ? PT_P : PT_OFF;
            PT_P:     nb = (c == CH_P) ? PT_SL : PT_OFF;
            PT_SL:
            begin
                handover = (c == CH_SLASH);
                nb       = PT_OFF;
            end
            default:  nb = PT_OFF;
        endcase

        // main tracker
        case (phase_reg)
            PH_LEAD:
            begin
                if (!ws)
                begin
                    np        = PH_METHOD;
                    do_method = 1'b1;
                end
            end
            PH_METHOD:
            begin
                if (ws)
                begin
                    np = method_ok ? PH_SLASH_WS : PH_FAIL;
                end
                else
                begin
                    do_method = 1'b1;
                end
            end
            PH_SLASH_WS:
            begin
                if (c == CH_SLASH)
                begin
                    np = PH_D_WS;
                    nb = PT_WS;
                end
                else if (!ws)
                begin
                    np = PH_FAIL;
                end
            end
            PH_D_WS:
            begin
                if (c == CH_H)
                begin
                    np = PH_D_T1;
                end
                else if (!ws)
                begin
                    np = PH_FAIL;
                end
            end
            PH_D_T1: np = (c == CH_T) ? PH_D_T2 : PH_FAIL;
            PH_D_T2: np = (c == CH_T) ? PH_D_P : PH_FAIL;
            PH_D_P:  np = (c == CH_P) ? PH_D_SL : PH_FAIL;
            PH_D_SL:
            begin
                if (c == CH_SLASH)
                begin
                    np        = PH_MAJ_WS;
                    clear_ver = 1'b1;
                end
                else
                begin
                    np = PH_FAIL;
                end
            end
            PH_MAJ_WS:
            begin
                if (c == CH_MINUS)
                begin
                    np           = PH_MAJ_SIGN;
                    maj_neg_next = 1'b1;
                end
                else if (c == CH_PLUS)
                begin
                    np = PH_MAJ_SIGN;
                end
                else if (dig)
                begin
                    np          = PH_MAJ_DIG;
                    maj_nz_next = maj_nz_reg || nonzero_dig;
                end
                else if (!ws)
                begin
                    np = PH_FAIL;
                end
            end
            PH_MAJ_SIGN:
            begin
                if (dig)
                begin
                    np          = PH_MAJ_DIG;
                    maj_nz_next = maj_nz_reg || nonzero_dig;
                end
                else
                begin
                    np = PH_FAIL;
                end
            end
            PH_MAJ_DIG:
            begin
                if (dig)
                begin
                    maj_nz_next = maj_nz_reg || nonzero_dig;
                end
                else
                begin
                    np = (c == CH_DOT) ? PH_MIN_WS : PH_FAIL;
                end
            end
            PH_MIN_WS:
            begin
                if (c == CH_MINUS)
                begin
                    np           = PH_MIN_SIGN;
                    min_neg_next = 1'b1;
                end
                else if (c == CH_PLUS)
                begin
                    np = PH_MIN_SIGN;
                end
                else if (dig)
                begin
                    np           = PH_MIN_DIG;
                    verdict_next = 1'b1;
                    min_nz_next  = min_nz_reg || nonzero_dig;
                end
                else if (!ws)
                begin
                    np = PH_FAIL;
                end
            end
            PH_MIN_SIGN:
            begin
                if (dig)
                begin
                    np           = PH_MIN_DIG;
                    verdict_next = 1'b1;
                    min_nz_next  = min_nz_reg || nonzero_dig;
                end
                else
                begin
                    np = PH_FAIL;
                end
            end
            PH_MIN_DIG:
            begin
                if (dig)
                begin
                    min_nz_next = min_nz_reg || nonzero_dig;
                end
                else
                begin
                    np = PH_DONE;
                end
            end
            PH_DONE: np = PH_DONE;
            default: np = PH_FAIL;
        endcase

        if (do_method)
        begin
            cand_next = cand_take;
            pos_next  = pos_take;
        end
        if (verdict_next)
        begin
            nb = PT_OFF;
        end
        // path form takes over when the direct form fails
        if (handover && (np == PH_FAIL))
        begin
            np        = PH_MAJ_WS;
            clear_ver = 1'b1;
        end
        if (clear_ver)
        begin
            maj_neg_next = 1'b0;
            maj_nz_next  = 1'b0;
            min_neg_next = 1'b0;
            min_nz_next  = 1'b0;
        end
        phase_next = np;
        path_next  = nb;

        // a zero byte ends the text, nothing moves after it
        if (ended_reg || (c == CH_NUL) || !take)
        begin
            phase_next   = phase_reg;
            path_next    = path_reg;
            cand_next    = cand_reg;
            pos_next     = pos_reg;
            maj_neg_next = maj_neg_reg;
            maj_nz_next  = maj_nz_reg;
            min_neg_next = min_neg_reg;
            min_nz_next  = min_nz_reg;
            verdict_next = verdict_reg;
            ended_next   = ended_reg || (take && (c == CH_NUL));
        end

        if (take && item.last)
        begin
            res_push     = 1'b1;
            res_value    = verdict_next && maj_nz_next && !maj_neg_next &&
                           !(min_neg_next && min_nz_next);
            phase_next   = PH_LEAD;
            path_next    = PT_OFF;
            cand_next    = '1;
            pos_next     = '0;
            maj_neg_next = 1'b0;
            maj_nz_next  = 1'b0;
            min_neg_next = 1'b0;
            min_nz_next  = 1'b0;
            verdict_next = 1'b0;
            ended_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            path_reg    <= PT_OFF;
            cand_reg    <= '1;
            pos_reg     <= '0;
            maj_neg_reg <= 1'b0;
            maj_nz_reg  <= 1'b0;
            min_neg_reg <= 1'b0;
            min_nz_reg  <= 1'b0;
            verdict_reg <= 1'b0;
            ended_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            path_reg    <= path_next;
            cand_reg    <= cand_next;
            pos_reg     <= pos_next;
            maj_neg_reg <= maj_neg_next;
            maj_nz_reg  <= maj_nz_next;
            min_neg_reg <= min_neg_next;
            min_nz_reg  <= min_nz_next;
            verdict_reg <= verdict_next;
            ended_reg   <= ended_next;
        end
    end

    `HRLD_ASSERT_NXT(a_back_msg_reset, clk, rst_n, take && item.last, (pos_reg == '0) && !verdict_reg && (phase_reg == PH_LEAD))
    `HRLD_ASSERT_IMP(a_back_path_off, clk, rst_n, verdict_reg, path_reg == PT_OFF)
    `HRLD_ASSERT_IMP(a_back_verdict_phase, clk, rst_n, verdict_reg, (phase_reg == PH_MIN_DIG) || (phase_reg == PH_DONE))

endmodule

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrld_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int IDLE_PERCENT = 38;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 200_000;
    localparam int RANDOM_BYTES = 720;
    localparam int NO_VERDICT   = -1;
    localparam int CASE_COUNT   = 24;

    typedef struct {
        string text;
        int    zero_at;
        int    verdict;
    } request_case_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic       is_request;

    http_request_line_detector u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .empty      (empty),
        .pop        (pop),
        .is_request (is_request)
    );

    string method_words [METHOD_COUNT] = '{
        "GET", "POST", "PUT", "DELETE", "PATCH", "HEAD", "CONNECT", "TRACE", "OPTIONS"
    };

    // message text, byte replaced by a zero byte (or -1), verdict (or -1 to predict)
    request_case_t request_cases [CASE_COUNT] = '{
        '{"GET / HTTP/1.0", -1, 1},
        '{"POST /api HTTP/1.1\015\n", -1, -1},
        '{"PUT  /  HTTP/ 1 . 0", -1, -1},
        '{"\t\n DELETE\013/\014HTTP/10.0", -1, -1},
        '{"PATCH /x HTTP/+1.-0", -1, -1},
        '{"HEAD / HTTP/0.9", -1, -1},
        '{"CONNECT / HTTP/-1.0", -1, -1},
        '{"TRACE / HTTP/1.-5", -1, -1},
        '{"OPTIONS * HTTP/1.1", -1, -1},
        '{"GETX / HTTP/1.1", -1, -1},
        '{"get / HTTP/1.1", -1, 0},
        '{"OPTIONSX / HTTP/1.1", -1, 0},
        '{"GET / HTTP/1.", -1, -1},
        '{"GET / HTTP/-.1", -1, -1},
        '{"GET / HTTP/0000000000000000000000001.000000000000000000000000", -1, -1},
        '{"GET / HTTP/1.1 tail \377", -1, -1},
        '{"GET / HTTP/#1.1", 11, -1},
        '{"GET / HTTP/1.1#junk", 14, -1},
        '{"#", 0, 0},
        '{"\377", -1, 0},
        '{"GET /HTTP/1.1", -1, -1},
        '{"GET /a b HTTP/1.1", -1, -1},
        '{"GET /  HTTP/1.x HTTP/2.0", -1, -1},
        '{" \015\n\t", -1, 0}
    };

    // request line tracker state
    phase_t     req_phase;
    path_t      path_phase;
    logic [8:0] method_live;
    logic [2:0] method_len_seen;
    logic       major_neg;
    logic       major_nz;
    logic       minor_neg;
    logic       minor_nz;
    logic       minor_seen;
    logic       text_done;

    logic       expected_verdicts [$];
    logic [7:0] msg_bytes [$];
    int         mismatch_count = 0;
    int         hold_requests = 0;
    bit         send_steady = 1'b0;
    bit         take_steady = 1'b0;

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("[http_request_line_detector] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic clear_request_line();
        req_phase       = PH_LEAD;
        path_phase      = PT_OFF;
        method_live     = '1;
        method_len_seen = '0;
        {major_neg, major_nz, minor_neg, minor_nz} = '0;
        minor_seen      = 1'b0;
        text_done       = 1'b0;
    endtask

    task automatic match_method(input logic [7:0] c);
        if (method_len_seen == 3'(METHOD_MAX))
        begin
            method_live = '0;
        end
        else
        begin
            for (int i = 0; i < METHOD_COUNT; i++)
            begin
                if (method_live[i] && (method_words[i].len() <= int'(method_len_seen) ||
                    method_words[i][method_len_seen] != c))
                begin
                    method_live[i] = 1'b0;
                end
            end
            method_len_seen++;
        end
    endtask

    function automatic logic method_named();
        for (int i = 0; i < METHOD_COUNT; i++)
        begin
            if (method_live[i] && method_words[i].len() == int'(method_len_seen))
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic advance_request_line(input logic [7:0] c);
        logic   ws;
        logic   dig;
        logic   handover;
        phase_t np;
        path_t  nb;
        ws       = is_space(c);
        dig      = is_num(c);
        handover = 1'b0;
        np       = req_phase;
        nb       = path_phase;

        case (path_phase)
            PT_WS:    if (!ws) nb = PT_TOKEN;
            PT_TOKEN: if (ws) nb = PT_GAP;
            PT_GAP:   if (!ws) nb = (c == CH_H) ? PT_T1 : PT_OFF;
            PT_T1:    nb = (c == CH_T) ? PT_T2 : PT_OFF;
            PT_T2:    nb = (c == CH_T) ? PT_P : PT_OFF;
            PT_P:     nb = (c == CH_P) ? PT_SL : PT_OFF;
            PT_SL:
            begin
                handover = (c == CH_SLASH);
                nb = PT_OFF;
            end
            default:  nb = PT_OFF;
        endcase

        case (req_phase)
            PH_LEAD:
            begin
                if (!ws)
                begin
                    np = PH_METHOD;
                    match_method(c);
                end
            end
            PH_METHOD:
            begin
                if (ws) np = method_named() ? PH_SLASH_WS : PH_FAIL;
                else match_method(c);
            end
            PH_SLASH_WS:
            begin
                if (c == CH_SLASH)
                begin
                    np = PH_D_WS;
                    nb = PT_WS;
                end
                else if (!ws) np = PH_FAIL;
            end
            PH_D_WS:
            begin
                if (c == CH_H) np = PH_D_T1;
                else if (!ws) np = PH_FAIL;
            end
            PH_D_T1: np = (c == CH_T) ? PH_D_T2 : PH_FAIL;
            PH_D_T2: np = (c == CH_T) ? PH_D_P : PH_FAIL;
            PH_D_P:  np = (c == CH_P) ? PH_D_SL : PH_FAIL;
            PH_D_SL:
            begin
                if (c == CH_SLASH)
                begin
                    np = PH_MAJ_WS;
                    {major_neg, major_nz, minor_neg, minor_nz} = '0;
                end
                else np = PH_FAIL;
            end
            PH_MAJ_WS:
            begin
                if (c == CH_MINUS)
                begin
                    np = PH_MAJ_SIGN;
                    major_neg = 1'b1;
                end
                else if (c == CH_PLUS) np = PH_MAJ_SIGN;
                else if (dig)
                begin
                    np = PH_MAJ_DIG;
                    major_nz = major_nz | (c != CH_ZERO);
                end
                else if (!ws) np = PH_FAIL;
            end
            PH_MAJ_SIGN:
            begin
                if (dig)
                begin
                    np = PH_MAJ_DIG;
                    major_nz = major_nz | (c != CH_ZERO);
                end
                else np = PH_FAIL;
            end
            PH_MAJ_DIG:
            begin
                if (dig) major_nz = major_nz | (c != CH_ZERO);
                else np = (c == CH_DOT) ? PH_MIN_WS : PH_FAIL;
            end
            PH_MIN_WS:
            begin
                if (c == CH_MINUS)
                begin
                    np = PH_MIN_SIGN;
                    minor_neg = 1'b1;
                end
                else if (c == CH_PLUS) np = PH_MIN_SIGN;
                else if (dig)
                begin
                    np = PH_MIN_DIG;
                    minor_seen = 1'b1;
                    minor_nz = minor_nz | (c != CH_ZERO);
                end
                else if (!ws) np = PH_FAIL;
            end
            PH_MIN_SIGN:
            begin
                if (dig)
                begin
                    np = PH_MIN_DIG;
                    minor_seen = 1'b1;
                    minor_nz = minor_nz | (c != CH_ZERO);
                end
                else np = PH_FAIL;
            end
            PH_MIN_DIG:
            begin
                if (dig) minor_nz = minor_nz | (c != CH_ZERO);
                else np = PH_DONE;
            end
            PH_DONE: ;
            default: np = PH_FAIL;
        endcase

        if (minor_seen) nb = PT_OFF;
        // path form takes over only once the direct form is dead
        if (handover && np == PH_FAIL)
        begin
            np = PH_MAJ_WS;
            {major_neg, major_nz, minor_neg, minor_nz} = '0;
        end
        req_phase  = np;
        path_phase = nb;
    endtask

    task automatic scan_request_byte(input logic [7:0] c, input logic l,
                                     output logic has, output logic verdict);
        if (!text_done)
        begin
            if (c == CH_NUL) text_done = 1'b1;
            else advance_request_line(c);
        end
        has = l;
        verdict = 1'b0;
        if (l)
        begin
            verdict = minor_seen && major_nz && !major_neg && !(minor_neg && minor_nz);
            clear_request_line();
        end
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_byte(input logic [7:0] c, input logic l, input int typed);
        logic has;
        logic verdict;
        while (!send_steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        data_byte <= c;
        last_byte <= l;
        @(posedge clk);
        while (full) @(posedge clk);
        scan_request_byte(c, l, has, verdict);
        if (has)
        begin
            expected_verdicts.push_back((typed == NO_VERDICT) ? verdict : 1'(typed));
        end
        @(negedge clk);
    endtask

    task automatic send_message(input int typed);
        foreach (msg_bytes[i])
        begin
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1, typed);
        end
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] any_space();
        logic [7:0] pick;
        pick = 8'($urandom_range(5));
        return (pick == 8'd5) ? CH_SPACE : CH_TAB + pick;
    endfunction

    function automatic logic [7:0] any_visible();
        return 8'($urandom_range(126, 33));
    endfunction

    task automatic append_version();
        if ($urandom_range(9) == 0) msg_bytes.push_back(any_space());
        case ($urandom_range(9))
            0: msg_bytes.push_back(CH_MINUS);
            1: msg_bytes.push_back(CH_PLUS);
            default: ;
        endcase
        repeat ($urandom_range(3, ($urandom_range(19) == 0) ? 0 : 1))
        begin
            msg_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    task automatic compose_message();
        string word;
        msg_bytes.delete();
        if ($urandom_range(99) < 10)
        begin
            repeat ($urandom_range(12, 1)) msg_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(2)) msg_bytes.push_back(any_space());
        word = method_words[$urandom_range(METHOD_COUNT - 1)];
        if ($urandom_range(99) < 12) word = word.tolower();
        else if ($urandom_range(99) < 8) word = {word, "S"};
        append_text(word);
        repeat ($urandom_range(2, 1)) msg_bytes.push_back(any_space());
        msg_bytes.push_back(CH_SLASH);
        if ($urandom_range(1))
        begin
            repeat ($urandom_range(6, 1)) msg_bytes.push_back(any_visible());
            repeat ($urandom_range(2, 1)) msg_bytes.push_back(any_space());
        end
        else
        begin
            repeat ($urandom_range(2)) msg_bytes.push_back(any_space());
        end
        append_text("HTTP/");
        append_version();
        msg_bytes.push_back(CH_DOT);
        append_version();
        if ($urandom_range(1)) append_text("\015\n");
        repeat ($urandom_range(3)) msg_bytes.push_back(any_visible());
        if ($urandom_range(99) < 15)
        begin
            msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom_range(255));
        end
        if ($urandom_range(99) < 5)
        begin
            msg_bytes[$urandom_range(msg_bytes.size() - 1)] = CH_NUL;
        end
    endtask

    // result side
    initial
    begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= take_steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk)
    begin
        logic want;
        if (rst_n && pop && !empty)
        begin
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("is_request=%0b with no transaction pending",
                                          is_request));
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (is_request !== want)
                begin
                    report_mismatch($sformatf("is_request=%0b, expected %0b",
                                              is_request, want));
                end
            end
        end
    end

    initial
    begin
        int random_bytes;
        int msg_index;
        clear_request_line();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < CASE_COUNT; k++)
        begin
            msg_bytes.delete();
            append_text(request_cases[k].text);
            if (request_cases[k].zero_at >= 0) msg_bytes[request_cases[k].zero_at] = CH_NUL;
            send_message(request_cases[k].verdict);
        end

        // back up the result queue, then the byte queue
        hold_requests++;
        send_steady = 1'b1;
        repeat (16) send_byte(8'($urandom_range(255)), 1'b1, NO_VERDICT);
        send_steady = 1'b0;

        random_bytes = 0;
        msg_index = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            compose_message();
            send_steady = (msg_index >= 8 && msg_index < 16);
            take_steady = send_steady;
            send_message(NO_VERDICT);
            random_bytes += msg_bytes.size();
            msg_index++;
        end
        send_steady = 1'b0;
        take_steady = 1'b0;
        push <= 1'b0;

        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[http_request_line_detector] OK");
        end
        else
        begin
            $display("[http_request_line_detector] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/hrld_pkg.sv
rtl/hrld_front.sv
rtl/hrld_back.sv
rtl/http_request_line_detector.sv
bench/testbench.sv
